// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the RTL. Build with NO_ASSERTIONS defined to
// drop every assertion from the design.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: implication");

// Next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/mrq_pkg.sv =====
// ----------------------------------------------------------------------------
// mrq_pkg
// Types and constants for the message ring queue with front insert.
// ----------------------------------------------------------------------------
package mrq_pkg;

    // Storage geometry
    localparam int DEPTH = 256;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int MSG_W = 32;
    localparam int ACT_W = 2;

    // Action codes
    localparam logic [ACT_W-1:0] ACT_SEND = 2'd0;
    localparam logic [ACT_W-1:0] ACT_JAM  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_RECV = 2'd2;

    // Input transaction
    typedef struct packed {
        logic [ACT_W-1:0] action;
        logic [MSG_W-1:0] message;
    } in_item_t;

    // Result transaction
    typedef struct packed {
        logic             ok;
        logic [MSG_W-1:0] data;
        logic [CNT_W-1:0] count;
        logic             empty_res;
        logic             full_res;
    } out_item_t;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_EXEC = 3'b010,
        ST_RESP = 3'b100
    } mrq_state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic cfg_wr;
        logic latch_in;
        logic exec;
        logic load_out;
    } mrq_cmd_t;

endpackage

// ===== rtl/mrq_ctrl.sv =====
// ----------------------------------------------------------------------------
// mrq_ctrl
// Sequencing for the queue: accept, execute, deliver. Owns the handshakes.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mrq_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    output mrq_pkg::mrq_cmd_t cmd
);
    import mrq_pkg::*;

    mrq_state_t state_reg;
    mrq_state_t state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       out_free;

    // Handshake readiness
    assign cfg_ready = (state_reg == ST_IDLE);
    assign in_ready  = (state_reg == ST_IDLE) && !cfg_valid;
    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || out_ready;

    // Commands
    always_comb
    begin
        cmd          = '0;
        cmd.cfg_wr   = cfg_valid && cfg_ready;
        cmd.latch_in = in_valid && in_ready;
        cmd.exec     = (state_reg == ST_EXEC);
        cmd.load_out = (state_reg == ST_RESP) && out_free;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd.latch_in)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_RESP;
            end
            ST_RESP:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output valid flag
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Checks
    `ASSERT_NEXT(a_accept_to_exec, clk, rst_n, in_valid && in_ready, state_reg == ST_EXEC)
    `ASSERT_NEXT(a_exec_to_resp, clk, rst_n, state_reg == ST_EXEC, state_reg == ST_RESP)
    `ASSERT_IMPLY(a_cfg_not_with_item, clk, rst_n, cfg_valid && cfg_ready, !(in_valid && in_ready))
    `ASSERT_NEXT(a_load_sets_valid, clk, rst_n, cmd.load_out, out_valid_reg)

endmodule

// ===== rtl/mrq_dp.sv =====
// ----------------------------------------------------------------------------
// mrq_dp
// Queue datapath: slot memory, head/tail pointers, entry count, capacity
// register and the result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mrq_dp (
    input  logic                       clk,
    input  logic                       rst_n,
    input  mrq_pkg::mrq_cmd_t          cmd,
    input  mrq_pkg::in_item_t          in_data,
    input  logic [mrq_pkg::CNT_W-1:0]  cfg_data,
    output mrq_pkg::out_item_t         out_data
);
    import mrq_pkg::*;

    // Slot memory
    logic [MSG_W-1:0] mem [DEPTH];
    logic [MSG_W-1:0] rd_data_reg;

    // Control state
    logic [CNT_W-1:0] cap_reg;
    logic [PTR_W-1:0] head_reg;
    logic [PTR_W-1:0] head_next;
    logic [PTR_W-1:0] tail_reg;
    logic [PTR_W-1:0] tail_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    // Latched transaction and staged result
    logic [ACT_W-1:0] act_reg;
    logic [MSG_W-1:0] msg_reg;
    logic             res_ok_reg;
    logic             res_rx_reg;
    logic [CNT_W-1:0] res_count_reg;
    logic             res_empty_reg;
    logic             res_full_reg;
    out_item_t        out_reg;

    logic [CNT_W-1:0] eff_cap;
    logic [CNT_W-1:0] cap_m1;
    logic [CNT_W-1:0] tail_inc;
    logic [CNT_W-1:0] head_inc;
    logic [PTR_W-1:0] head_dec;
    logic             is_put;
    logic             is_get;
    logic             put_ok;
    logic             get_ok;
    logic             wr_en;
    logic [PTR_W-1:0] wr_addr;
    logic             rd_en;

    // Effective capacity: zero reads as one, saturate at the depth
    always_comb
    begin
        if (cap_reg == '0)
        begin
            eff_cap = CNT_W'(1);
        end
        else if (cap_reg > CNT_W'(DEPTH))
        begin
            eff_cap = CNT_W'(DEPTH);
        end
        else
        begin
            eff_cap = cap_reg;
        end
    end

    assign cap_m1 = eff_cap - CNT_W'(1);

    // Operation decode and pointer arithmetic
    assign is_put   = (act_reg == ACT_SEND) || (act_reg == ACT_JAM);
    assign is_get   = (act_reg == ACT_RECV);
    assign put_ok   = is_put && (count_reg < eff_cap);
    assign get_ok   = is_get && (count_reg != '0);
    assign tail_inc = {1'b0, tail_reg} + CNT_W'(1);
    assign head_inc = {1'b0, head_reg} + CNT_W'(1);
    assign head_dec = (head_reg == '0) ? cap_m1[PTR_W-1:0] : head_reg - PTR_W'(1);

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (put_ok)
        begin
            count_next = count_reg + CNT_W'(1);
            if (act_reg == ACT_JAM)
            begin
                head_next = head_dec;
            end
            else
            begin
                tail_next = (tail_inc >= eff_cap) ? '0 : tail_inc[PTR_W-1:0];
            end
        end
        else if (get_ok)
        begin
            count_next = count_reg - CNT_W'(1);
            head_next  = (head_inc >= eff_cap) ? '0 : head_inc[PTR_W-1:0];
        end
    end

    assign wr_en   = cmd.exec && put_ok;
    assign wr_addr = (act_reg == ACT_JAM) ? head_dec : tail_reg;
    assign rd_en   = cmd.exec && get_ok;

    // Memory write and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= msg_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[head_reg];
        end
    end

    // Pointers, count and capacity
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg   <= CNT_W'(DEPTH);
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else if (cmd.cfg_wr)
        begin
            cap_reg   <= cfg_data;
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else if (cmd.exec)
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    // Transaction latch
    always_ff @(posedge clk)
    begin
        if (cmd.latch_in)
        begin
            act_reg <= in_data.action;
            msg_reg <= in_data.message;
        end
    end

    // Staged status of the executed operation
    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            res_ok_reg    <= put_ok || get_ok;
            res_rx_reg    <= get_ok;
            res_count_reg <= count_next;
            res_empty_reg <= (count_next == '0);
            res_full_reg  <= (count_next == eff_cap);
        end
    end

    // Output register
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_reg.ok        <= res_ok_reg;
            out_reg.data      <= res_rx_reg ? rd_data_reg : '0;
            out_reg.count     <= res_count_reg;
            out_reg.empty_res <= res_empty_reg;
            out_reg.full_res  <= res_full_reg;
        end
    end

    assign out_data = out_reg;

    // Checks
    `ASSERT_IMPLY(a_count_in_range, clk, rst_n, 1'b1, count_reg <= eff_cap)
    `ASSERT_IMPLY(a_head_in_range, clk, rst_n, 1'b1, CNT_W'(head_reg) < eff_cap)
    `ASSERT_IMPLY(a_tail_in_range, clk, rst_n, 1'b1, CNT_W'(tail_reg) < eff_cap)

endmodule

// ===== rtl/message_ring_queue_with_jam_core.sv =====
// ----------------------------------------------------------------------------
// message_ring_queue_with_jam_core
// Ring-buffer queue of 32-bit messages with tail send, front jam and receive.
// ----------------------------------------------------------------------------
// Each input transaction is a send (append at tail), a jam send (insert ahead
// of the oldest entry) or a receive (remove from head); every transaction
// yields exactly one result with ok, data, count, empty_res and full_res. A
// send to a full queue, a receive from an empty one, or an unused action code
// returns ok 0 and data 0 and leaves the queue untouched. The queue holds up
// to 256 words in a single-port-write, registered-read slot memory; the
// capacity register (0 reads as 1, values above 256 saturate) sets the ring
// size and writing it empties the queue. Writes to capacity are taken only
// between transactions. An accepted item is executed (with memory access),
// then its result is loaded into the output register and offered; the next
// item is accepted only after that load, once the sequencer is back in idle,
// so items do not overlap. A new item is accepted while the previous result
// still waits in the output register, and the block stalls only when that
// register is still occupied at delivery.
// Slots never written hold unknown data, but only written slots are read.
// ----------------------------------------------------------------------------
module message_ring_queue_with_jam_core (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  mrq_pkg::in_item_t          in_data,
    output logic                       out_valid,
    input  logic                       out_ready,
    output mrq_pkg::out_item_t         out_data,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [mrq_pkg::CNT_W-1:0]  cfg_data
);
    import mrq_pkg::*;

    mrq_cmd_t cmd;

    // Sequencer
    mrq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cmd       (cmd)
    );

    // Storage and arithmetic
    mrq_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .in_data  (in_data),
        .cfg_data (cfg_data),
        .out_data (out_data)
    );

endmodule

// ===== verif/message_ring_queue_with_jam_core_tb.sv =====
`timescale 1ns / 100ps
// ============================================================================
// Message ring queue with jam testbench
// ----------------------------------------------------------------------------
// Drives send, jam send, receive and unused-code transactions into the
// queue and checks every result field against a ring-buffer predictor kept
// in step with accepted transactions. The run opens with short directed
// sequences at the full, single-slot and two-slot sizes. It then runs random
// fill/drain/mixed bursts over several capacities, including the saturating
// encoding, under three sender/receiver idling profiles.
// ============================================================================
module message_ring_queue_with_jam_core_tb;
    import mrq_pkg::*;

    // Unused action code: must be refused without touching the queue
    localparam logic [ACT_W-1:0] ACT_NONE = 2'd3;
    localparam int STALL_LIMIT = 2000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    in_item_t in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    out_item_t out_data;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CNT_W-1:0] cfg_data = '0;

    // Stimulus backlog and idling profile
    in_item_t op_backlog[$];
    logic [CNT_W-1:0] cap_backlog[$];
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    // Predicted queue contents
    logic [MSG_W-1:0] ring_slots [DEPTH];
    int ring_head = 0;
    int ring_tail = 0;
    int ring_count = 0;
    logic [CNT_W-1:0] ring_cap = CNT_W'(256);
    out_item_t expected_results[$];

    // Progress counters
    int ops_queued = 0;
    int results_checked = 0;
    int caps_written = 0;
    int mismatches = 0;
    int stall_cycles = 0;

    message_ring_queue_with_jam_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Capacity as the ring actually uses it: zero acts as one, saturates at DEPTH
    function automatic int usable_slots(logic [CNT_W-1:0] cap);
        if (cap == 0)
            return 1;
        if (cap > DEPTH)
            return DEPTH;
        return int'(cap);
    endfunction

    // Apply one transaction to the predicted ring and return its result
    function automatic out_item_t ring_apply(in_item_t op);
        out_item_t r;
        int lim;
        lim = usable_slots(ring_cap);
        r = '0;
        if (op.action == ACT_SEND || op.action == ACT_JAM)
        begin
            if (ring_count < lim)
            begin
                if (op.action == ACT_SEND)
                begin
                    ring_slots[ring_tail] = op.message;
                    ring_tail = (ring_tail + 1 >= lim) ? 0 : ring_tail + 1;
                end
                else
                begin
                    ring_head = (ring_head == 0) ? lim - 1 : ring_head - 1;
                    ring_slots[ring_head] = op.message;
                end
                ring_count++;
                r.ok = 1'b1;
            end
        end
        else if (op.action == ACT_RECV)
        begin
            if (ring_count != 0)
            begin
                r.data = ring_slots[ring_head];
                ring_head = (ring_head + 1 >= lim) ? 0 : ring_head + 1;
                ring_count--;
                r.ok = 1'b1;
            end
        end
        r.count = CNT_W'(ring_count);
        r.empty_res = (ring_count == 0);
        r.full_res = (ring_count == lim);
        return r;
    endfunction

    task automatic check_field(string field, logic [MSG_W-1:0] want, logic [MSG_W-1:0] got);
        if (want !== got)
        begin
            mismatches++;
            $display("%0t: %s mismatch expected %h actual %h", $time, field, want, got);
        end
    endtask

    // Driver: feeds queued transactions, random receiver stalls, capacity writes
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data <= '0;
            out_ready <= 1'b0;
            cfg_valid <= 1'b0;
            cfg_data <= '0;
        end
        else
        begin
            if (!in_valid || in_ready)
            begin
                if (op_backlog.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    in_valid <= 1'b1;
                    in_data <= op_backlog.pop_front();
                end
                else
                    in_valid <= 1'b0;
            end
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
            if (cfg_valid && cfg_ready)
                cfg_valid <= 1'b0;
            else if (!cfg_valid && cap_backlog.size() > 0)
            begin
                cfg_valid <= 1'b1;
                cfg_data <= cap_backlog.pop_front();
            end
        end
    end

    // Monitor: predicts on input acceptance, checks each delivered result
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((cfg_valid && cfg_ready) || (in_valid && in_ready)
                || (out_valid && out_ready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (cfg_valid && cfg_ready)
            begin
                ring_cap = cfg_data;
                ring_head = 0;
                ring_tail = 0;
                ring_count = 0;
                caps_written++;
            end
            if (in_valid && in_ready)
            begin
                expected_results.push_back(ring_apply(in_data));
            end
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected result expected none actual %h", $time, out_data);
                end
                else
                begin
                    out_item_t want;
                    want = expected_results.pop_front();
                    check_field("ok", want.ok, out_data.ok);
                    check_field("data", want.data, out_data.data);
                    check_field("count", want.count, out_data.count);
                    check_field("empty_res", want.empty_res, out_data.empty_res);
                    check_field("full_res", want.full_res, out_data.full_res);
                    results_checked++;
                end
            end
        end
    end

    // Watchdog: too long without any transaction
    initial
    begin
        while (stall_cycles < STALL_LIMIT)
            @(posedge clk);
        $display("simulation failed");
        $finish;
    end

    task automatic push_op(logic [ACT_W-1:0] act, logic [MSG_W-1:0] msg);
        in_item_t op;
        op.action = act;
        op.message = msg;
        op_backlog.push_back(op);
        ops_queued++;
    endtask

    // Sender holds off until every queued transaction has its result
    task automatic wait_drained();
        while (results_checked != ops_queued)
            @(posedge clk);
    endtask

    task automatic write_capacity(logic [CNT_W-1:0] cap);
        int target;
        target = caps_written + 1;
        cap_backlog.push_back(cap);
        while (caps_written < target)
            @(posedge clk);
    endtask

    function automatic logic [MSG_W-1:0] random_message();
        int pick;
        pick = $urandom_range(99);
        if (pick < 8)
            return '0;
        if (pick < 16)
            return '1;
        return $urandom;
    endfunction

    // Bursts that fill, drain or mix, sized to the ring so full and empty recur
    task automatic random_traffic(int lim, int total);
        int left;
        int span;
        int mode;
        int pick;
        logic [ACT_W-1:0] act;
        left = total;
        while (left > 0)
        begin
            span = $urandom_range(1, 2 * lim + 2);
            if (span > left)
                span = left;
            mode = $urandom_range(2);
            repeat (span)
            begin
                pick = $urandom_range(99);
                if (pick < 3)
                    act = ACT_NONE;
                else if ((mode == 0 && pick < 80) || (mode == 1 && pick >= 80)
                         || (mode == 2 && pick < 50))
                    act = $urandom_range(1) ? ACT_SEND : ACT_JAM;
                else
                    act = ACT_RECV;
                push_op(act, random_message());
            end
            left -= span;
        end
    endtask

    task automatic run_phase(logic [CNT_W-1:0] cap, int total, int s_idle, int r_idle);
        send_idle_pct = s_idle;
        recv_idle_pct = r_idle;
        write_capacity(cap);
        random_traffic(usable_slots(cap), total);
        wait_drained();
    endtask

    // Stimulus sequence
    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        send_idle_pct = 7;
        recv_idle_pct = 48;

        // Reset capacity: refused receive, head wrap on jam, unused code
        push_op(ACT_RECV, 32'hDEADBEEF);
        push_op(ACT_SEND, 32'h00000000);
        push_op(ACT_SEND, 32'hFFFFFFFF);
        push_op(ACT_JAM, 32'hA5A5A5A5);
        push_op(ACT_NONE, 32'hFFFFFFFF);
        push_op(ACT_RECV, 32'h0);
        push_op(ACT_RECV, 32'h0);
        push_op(ACT_RECV, 32'h0);
        push_op(ACT_RECV, 32'h0);
        push_op(ACT_JAM, 32'h12345678);
        push_op(ACT_RECV, 32'h0);
        wait_drained();

        // Capacity zero acts as a single slot: full after one entry
        write_capacity(CNT_W'(0));
        push_op(ACT_SEND, 32'h5A5A5A5A);
        push_op(ACT_SEND, 32'h11111111);
        push_op(ACT_JAM, 32'h22222222);
        push_op(ACT_RECV, 32'h0);
        push_op(ACT_RECV, 32'h0);
        push_op(ACT_JAM, 32'h00000000);
        push_op(ACT_NONE, 32'h0);
        push_op(ACT_RECV, 32'h0);
        wait_drained();

        // Two slots: jam ahead of a send, then overflow and underflow
        write_capacity(CNT_W'(2));
        push_op(ACT_SEND, 32'hCAFEF00D);
        push_op(ACT_JAM, 32'h0BADF00D);
        push_op(ACT_SEND, 32'h33333333);
        push_op(ACT_RECV, 32'h0);
        push_op(ACT_RECV, 32'h0);
        push_op(ACT_RECV, 32'h0);
        wait_drained();

        // Receiver stalls heavily
        run_phase(CNT_W'(1), 120, 7, 48);
        run_phase(CNT_W'(2), 120, 7, 48);
        run_phase(CNT_W'(3), 120, 7, 48);
        run_phase(CNT_W'($urandom_range(4, 16)), 150, 7, 48);

        // Sender gaps heavily; oversized capacity saturates, fill to full and drain
        send_idle_pct = 48;
        recv_idle_pct = 7;
        write_capacity(CNT_W'(511));
        repeat (DEPTH + 2)
            push_op($urandom_range(1) ? ACT_SEND : ACT_JAM, random_message());
        repeat (DEPTH + 2)
            push_op(ACT_RECV, random_message());
        random_traffic(DEPTH, 14);
        wait_drained();
        run_phase(CNT_W'(255), 150, 48, 7);

        // No idling on either side
        run_phase(CNT_W'(256), 150, 0, 0);
        run_phase(CNT_W'($urandom_range(1, 256)), 200, 0, 0);

        wait_drained();
        repeat (10) @(posedge clk);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
